[hw/rtl/idck_pkg.sv]
// ----------------------------------------------------------------------------
// idck_pkg
// Shared types, constants and small arithmetic helpers for the identity
// number check and upgrade unit.
// ----------------------------------------------------------------------------
package idck_pkg;

  localparam int unsigned STORE_DEPTH = 18;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic [4:0] LONG_LEN  = 5'd18;
  localparam logic [4:0] SHORT_LEN = 5'd15;
  localparam logic [4:0] BODY_LEN  = 5'd17;
  localparam logic [4:0] COUNT_CAP = 5'd19;
  localparam logic [4:0] HEAD_LEN  = 5'd6;
  localparam logic [4:0] CENT_GAP  = 5'd2;
  localparam logic [4:0] CENT_HI_IDX = 5'd6;
  localparam logic [4:0] CENT_LO_IDX = 5'd7;
  localparam logic [4:0] LAST_IDX    = 5'd17;
  localparam logic [4:0] SEQ0_POS    = 5'd12;
  localparam logic [4:0] SEQ1_POS    = 5'd13;
  localparam logic [4:0] SEQ2_POS    = 5'd14;

  localparam logic [3:0] MODULUS = 4'd11;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_SIX  = 8'h36;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_X    = 8'h58;

  // Weighted contribution of the inserted century digits, reduced mod 11:
  // 2 * 1 + 1 * 8 for century 18 and 2 * 1 + 1 * 9 for century 19.
  localparam logic [3:0] CENT_OLD_ADD = 4'd10;
  localparam logic [3:0] CENT_NEW_ADD = 4'd0;

  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_CHAR    = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FINISH,
    S_READ,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic       load;
    logic       kind;
    logic       verdict;
    logic [7:0] ch;
    logic       run_end;
  } load_req_t;

  function automatic logic [3:0] weight_of(input logic [4:0] pos);
    logic [3:0] w;
    case (pos)
      5'd0:    w = 4'd7;
      5'd1:    w = 4'd9;
      5'd2:    w = 4'd10;
      5'd3:    w = 4'd5;
      5'd4:    w = 4'd8;
      5'd5:    w = 4'd4;
      5'd6:    w = 4'd2;
      5'd7:    w = 4'd1;
      5'd8:    w = 4'd6;
      5'd9:    w = 4'd3;
      5'd10:   w = 4'd7;
      5'd11:   w = 4'd9;
      5'd12:   w = 4'd10;
      5'd13:   w = 4'd5;
      5'd14:   w = 4'd8;
      5'd15:   w = 4'd4;
      5'd16:   w = 4'd2;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] check_char(input logic [3:0] r);
    logic [7:0] c;
    case (r)
      4'd0:    c = CH_ONE;
      4'd1:    c = CH_ZERO;
      4'd2:    c = CH_X;
      4'd3:    c = CH_NINE;
      4'd4:    c = CH_EIGHT;
      4'd5:    c = 8'h37;
      4'd6:    c = CH_SIX;
      4'd7:    c = 8'h35;
      4'd8:    c = 8'h34;
      4'd9:    c = 8'h33;
      4'd10:   c = 8'h32;
      default: c = CH_ZERO;
    endcase
    return c;
  endfunction

  // Reduces a product below 128 modulo 11 by conditional subtraction.
  function automatic logic [3:0] mod11_small(input logic [6:0] p);
    logic [6:0] v;
    v = p;
    if (v >= 7'd88) v = v - 7'd88;
    if (v >= 7'd44) v = v - 7'd44;
    if (v >= 7'd22) v = v - 7'd22;
    if (v >= 7'd11) v = v - 7'd11;
    return v[3:0];
  endfunction

  function automatic logic [3:0] add_mod11(input logic [3:0] r, input logic [3:0] p);
    logic [4:0] s;
    s = {1'b0, r} + {1'b0, p};
    if (s >= {1'b0, MODULUS}) s = s - {1'b0, MODULUS};
    return s[3:0];
  endfunction

endpackage

[hw/rtl/idck_store.sv]
// ----------------------------------------------------------------------------
// idck_store
// Character buffer: one write port and one synchronous read port with a
// registered read data output.
// ----------------------------------------------------------------------------
module idck_store
  import idck_pkg::*;
(
  input  logic       clk,
  input  mem_wr_t    wr,
  input  mem_rd_t    rd,
  output logic [7:0] rd_data
);

  logic [7:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

[hw/rtl/idck_ctrl.sv]
// ----------------------------------------------------------------------------
// idck_ctrl
// Running check sums, character count and the sequencer that emits the
// verdict or reads the buffer back to build the upgraded number.
// ----------------------------------------------------------------------------
module idck_ctrl
  import idck_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] char_in,
  input  logic       is_final,
  output mem_wr_t    mem_wr,
  output mem_rd_t    mem_rd,
  input  logic [7:0] rd_data,
  input  logic       slot_free,
  output load_req_t  load_req
);

  state_t     state;
  state_t     state_next;
  logic [4:0] count;
  logic [3:0] sum_long;
  logic [3:0] sum_short;
  logic       bad;
  logic       old_seq;
  logic [4:0] idx;
  logic [7:0] last_ch;

  logic       accept;
  logic       digit;
  logic [3:0] dv;
  logic [4:0] short_pos;
  logic [7:0] prod_long;
  logic [7:0] prod_short;
  logic       upgrade;
  logic       clear_run;
  logic [7:0] cent_ch;
  logic [3:0] total;

  assign char_stall = (state != S_IDLE);
  assign accept     = char_valid && (state == S_IDLE);
  assign digit      = char_in inside {[CH_ZERO:CH_NINE]};
  assign dv         = digit ? char_in[3:0] : 4'd0;
  assign short_pos  = (count < HEAD_LEN) ? count : count + CENT_GAP;
  assign prod_long  = dv * weight_of(count);
  assign prod_short = dv * weight_of(short_pos);
  assign upgrade    = (count == SHORT_LEN) && !bad;
  assign cent_ch    = old_seq ? CH_EIGHT : CH_NINE;
  assign total      = add_mod11(sum_short, old_seq ? CENT_OLD_ADD : CENT_NEW_ADD);
  assign clear_run  = ((state == S_FINISH) && !upgrade && slot_free) ||
                      ((state == S_LOAD) && slot_free && (idx == LAST_IDX));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && is_final) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (upgrade) begin
          state_next = S_READ;
        end else if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (slot_free) state_next = (idx == LAST_IDX) ? S_IDLE : S_READ;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mem_wr.en   = accept && (count < LONG_LEN);
    mem_wr.addr = count[ADDR_W-1:0];
    mem_wr.data = char_in;
    mem_rd.en   = (state == S_READ);
    mem_rd.addr = (idx < HEAD_LEN) ? idx[ADDR_W-1:0] : (idx - CENT_GAP);
    load_req    = '0;
    case (state)
      S_FINISH: begin
        load_req.load    = slot_free && !upgrade;
        load_req.kind    = KIND_VERDICT;
        load_req.verdict = (count == LONG_LEN) && !bad &&
                           (last_ch == check_char(sum_long));
        load_req.run_end = 1'b1;
      end
      S_LOAD: begin
        load_req.load    = slot_free;
        load_req.kind    = KIND_CHAR;
        load_req.run_end = (idx == LAST_IDX);
        if (idx == CENT_HI_IDX) begin
          load_req.ch = CH_ONE;
        end else if (idx == CENT_LO_IDX) begin
          load_req.ch = cent_ch;
        end else if (idx == LAST_IDX) begin
          load_req.ch = check_char(total);
        end else begin
          load_req.ch = rd_data;
        end
      end
      default: load_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      sum_long  <= '0;
      sum_short <= '0;
      bad       <= 1'b0;
      old_seq   <= 1'b0;
      idx       <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (count < COUNT_CAP) count <= count + 5'd1;
        if (count < BODY_LEN) begin
          sum_long <= add_mod11(sum_long, mod11_small(prod_long[6:0]));
          bad      <= bad | !digit;
        end
        if (count < SHORT_LEN) begin
          sum_short <= add_mod11(sum_short, mod11_small(prod_short[6:0]));
        end
        if (count == SEQ0_POS) begin
          old_seq <= (char_in == CH_NINE);
        end else if (count == SEQ1_POS) begin
          old_seq <= old_seq && (char_in == CH_NINE);
        end else if (count == SEQ2_POS) begin
          old_seq <= old_seq && (char_in >= CH_SIX) && (char_in <= CH_NINE);
        end
      end
      if (state == S_FINISH) idx <= '0;
      if ((state == S_LOAD) && slot_free) idx <= idx + 5'd1;
      if (clear_run) begin
        count     <= '0;
        sum_long  <= '0;
        sum_short <= '0;
        bad       <= 1'b0;
        old_seq   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) last_ch <= char_in;
  end

`ifndef SYNTHESIS
  a_final_to_finish: assert property (@(posedge clk) disable iff (rst)
    (char_valid && !char_stall && is_final) |=> (state == S_FINISH))
    else $error("final character did not start the finish step");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    (count <= COUNT_CAP))
    else $error("character count passed its cap");

  a_residues: assert property (@(posedge clk) disable iff (rst)
    (sum_long < MODULUS) && (sum_short < MODULUS))
    else $error("check sum residue out of range");

  a_run_cleared: assert property (@(posedge clk) disable iff (rst)
    ((state == S_LOAD) && slot_free && (idx == LAST_IDX)) |=>
      ((state == S_IDLE) && (count == 5'd0)))
    else $error("run state not cleared after the last upgraded character");
`endif

endmodule

[hw/rtl/id_number_check_and_upgrade_unit.sv]
// ----------------------------------------------------------------------------
// id_number_check_and_upgrade_unit
// Checks 18-character identity numbers and upgrades 15-character ones.
// ----------------------------------------------------------------------------
// Usage: characters enter on the char channel (char_valid, char_stall,
// char_in, is_final), one per transaction, with is_final set on the last
// character of a number. Results leave on the result channel (result_valid,
// result_stall, kind, verdict, char_out, run_end); run_end marks the last
// result of a number.
// A non-final character is taken whenever the unit is idle and gives no
// result. After the final character the input stalls while the number is
// finished: any number but a valid 15-character one gives one verdict
// transaction, which passes the finish state and then the output register.
// A valid 15-character number gives 18 character transactions; for each,
// the single read port of the character buffer is read, then the result is
// loaded into the output register.
// The output register lets the next characters enter while a verdict waits.
// When result_stall holds, the result stays in place and the finish step
// waits. Reset clears all control state and the output valid flag; buffer
// entries that reach the output are always written for the current number.
// ----------------------------------------------------------------------------
module id_number_check_and_upgrade_unit
  import idck_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] char_in,
  input  logic       is_final,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       kind,
  output logic       verdict,
  output logic [7:0] char_out,
  output logic       run_end
);

  mem_wr_t    mem_wr;
  mem_rd_t    mem_rd;
  logic [7:0] rd_data;
  logic       slot_free;
  load_req_t  load_req;

  assign slot_free = !result_valid || !result_stall;

  idck_store u_store (
    .clk     (clk),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (rd_data)
  );

  idck_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_in    (char_in),
    .is_final   (is_final),
    .mem_wr     (mem_wr),
    .mem_rd     (mem_rd),
    .rd_data    (rd_data),
    .slot_free  (slot_free),
    .load_req   (load_req)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_req.load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_req.load) begin
      kind     <= load_req.kind;
      verdict  <= load_req.verdict;
      char_out <= load_req.ch;
      run_end  <= load_req.run_end;
    end
  end

endmodule
